/* design/length_prefix_deframer_core_macros.svh */
// assertion macros for the length prefix deframer
`ifndef LENGTH_PREFIX_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LPD_ASSERT_IMP(lbl, c, r, a, b, m) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) else $error(m);
`define LPD_ASSERT_NXT(lbl, c, r, a, b, m) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) else $error(m);
`else
`define LPD_ASSERT_IMP(lbl, c, r, a, b, m)
`define LPD_ASSERT_NXT(lbl, c, r, a, b, m)
`endif
`endif

/* design/lpd_pkg.sv */
// shared types and constants of the length prefix deframer
`timescale 1ns / 1ps
`default_nettype none
package lpd_pkg;
	localparam int HDR_LEN = 4;
	localparam int HDR_CNT_W = $clog2(HDR_LEN);
	localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_LEN - 1);
	localparam int HDR_KEEP_W = 24;
	localparam int LEN_W = 32;
	localparam logic [LEN_W-1:0] RESET_MAX_LEN = 32'd65536;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_OVERSIZE = 2'd2
	} lpd_kind_t;

	typedef struct packed {
		lpd_kind_t  kind;
		logic [7:0] data;
		logic       last;
	} lpd_result_t;
endpackage
`default_nettype wire

/* design/lpd_front.sv */
// front end: header collection, length check and result classification
`timescale 1ns / 1ps
`default_nettype none
`include "length_prefix_deframer_core_macros.svh"
module lpd_front import lpd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic [7:0]        data_byte,
	input  wire logic              cfg_wr_en,
	input  wire logic [LEN_W-1:0]  cfg_wr_data,
	output      logic              push,
	output      lpd_result_t       push_data
);
	logic [HDR_KEEP_W-1:0] hdr_q;
	logic [HDR_CNT_W-1:0]  hcnt_q;
	logic                  in_pay_q;
	logic [LEN_W-1:0]      rem_q;
	logic                  err_q;
	logic [LEN_W-1:0]      max_q;

	logic             take;
	logic             is_pay;
	logic             hdr_done;
	logic [LEN_W-1:0] len;
	logic             over;
	logic             res_valid;

	assign take     = in_valid && !in_stall;
	assign is_pay   = in_pay_q && (rem_q != '0);
	assign hdr_done = (hcnt_q == HDR_LAST);
	assign len      = {hdr_q, data_byte};
	assign over     = (len > max_q);

	always_comb begin
		res_valid      = 1'b0;
		push_data.kind = KIND_PAYLOAD;
		push_data.data = 8'd0;
		push_data.last = 1'b0;
		priority if (err_q) begin
			res_valid = 1'b0;
		end else if (is_pay) begin
			res_valid      = 1'b1;
			push_data.data = data_byte;
			push_data.last = (rem_q == LEN_W'(1));
		end else if (!hdr_done) begin
			res_valid = 1'b0;
		end else if (over) begin
			res_valid      = 1'b1;
			push_data.kind = KIND_OVERSIZE;
		end else if (len == '0) begin
			res_valid      = 1'b1;
			push_data.kind = KIND_EMPTY;
			push_data.last = 1'b1;
		end else begin
			res_valid = 1'b0;
		end
	end

	assign push = take && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= RESET_MAX_LEN;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= '0;
			hcnt_q   <= '0;
			in_pay_q <= 1'b0;
			rem_q    <= '0;
			err_q    <= 1'b0;
		end else if (take && !err_q) begin
			if (is_pay) begin
				rem_q <= rem_q - LEN_W'(1);
				if (rem_q == LEN_W'(1)) begin
					in_pay_q <= 1'b0;
				end
			end else begin
				if (!hdr_done) begin
					in_pay_q <= 1'b0;
					hdr_q    <= {hdr_q[HDR_KEEP_W-9:0], data_byte};
					hcnt_q   <= hcnt_q + HDR_CNT_W'(1);
				end else begin
					hdr_q    <= '0;
					hcnt_q   <= '0;
					in_pay_q <= !over && (len != '0);
					if (over) begin
						err_q <= 1'b1;
					end else if (len != '0) begin
						rem_q <= len;
					end
				end
			end
		end
	end

	`LPD_ASSERT_NXT(a_err_sticky, clk, arst_n, err_q, err_q, "error flag cleared")
	`LPD_ASSERT_IMP(a_hdr_idle_in_pay, clk, arst_n, in_pay_q, hcnt_q == '0,
		"header count nonzero in payload")
endmodule
`default_nettype wire

/* design/lpd_queue.sv */
// short result queue between front and back
`timescale 1ns / 1ps
`default_nettype none
`include "length_prefix_deframer_core_macros.svh"
module lpd_queue import lpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire lpd_result_t push_data,
	output      logic        full,
	input  wire logic        pop,
	output      lpd_result_t pop_data,
	output      logic        empty
);
	lpd_result_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`LPD_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full, "push into full queue")
	`LPD_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !empty, "pop from empty queue")
endmodule
`default_nettype wire

/* design/lpd_back.sv */
// back end: output register fed from the result queue
`timescale 1ns / 1ps
`default_nettype none
module lpd_back import lpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire lpd_result_t q_data,
	output      logic        pop,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [1:0]  result_kind,
	output      logic [7:0]  payload_byte,
	output      logic        frame_last
);
	logic        vld_q;
	lpd_result_t res_q;

	assign pop = !q_empty && (!vld_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!vld_q || !out_stall) begin
			vld_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= q_data;
		end
	end

	assign out_valid    = vld_q;
	assign result_kind  = res_q.kind;
	assign payload_byte = res_q.data;
	assign frame_last   = res_q.last;
endmodule
`default_nettype wire

/* design/length_prefix_deframer_core.sv */
// top level of the length prefix deframer
`timescale 1ns / 1ps
`default_nettype none
// Splits a byte stream into frames, each led by a 4-byte big-endian length header.
// One byte is taken per clock while in_valid is high and in_stall is low; every
// byte is classified in the cycle it is taken. Results (payload byte, empty frame,
// oversize error) go into a four-entry queue and then into an output register.
// in_stall rises only while the queue holds four results waiting on a stalled
// output. After an oversize header every later byte is taken and dropped until
// reset. max_frame_length resets to 65536 and is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while idle (not enforced by the block).
module length_prefix_deframer_core import lpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [1:0]  result_kind,
	output      logic [7:0]  payload_byte,
	output      logic        frame_last
);
	logic        push;
	lpd_result_t push_data;
	logic        q_full;
	logic        q_empty;
	logic        pop;
	lpd_result_t pop_data;

	assign in_stall = q_full;

	lpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push),
		.push_data   (push_data)
	);

	lpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	lpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.frame_last   (frame_last)
	);
endmodule
`default_nettype wire
